FILE: design/cau_pkg.sv
// ---------------------------------------------------------------------------
// cau_pkg: shared types and constants for the complex arithmetic unit
// Operation codes, fixed field widths and the control bundle of a cell.
// ---------------------------------------------------------------------------
package cau_pkg;

	localparam int IN_W    = 16;
	localparam int KIND_W  = 3;
	localparam int RES_W   = 49;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 104;

	localparam int OPERAND_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF     = 16;

	localparam logic [KIND_W-1:0] K_ADD    = 3'd0;
	localparam logic [KIND_W-1:0] K_SUB_AB = 3'd1;
	localparam logic [KIND_W-1:0] K_SUB_BA = 3'd2;
	localparam logic [KIND_W-1:0] K_MUL    = 3'd3;
	localparam logic [KIND_W-1:0] K_DIV_AB = 3'd4;
	localparam logic [KIND_W-1:0] K_DIV_BA = 3'd5;

	typedef struct packed {
		logic valid;
		logic is_div;
		logic div_zero;
		logic neg_re;
		logic neg_im;
	} ctl_t;

endpackage

FILE: design/cau_cell.sv
// ---------------------------------------------------------------------------
// cau_cell: one step of the divider chain
// Produces one quotient bit for the real and the imaginary lane and hands
// the item, with its side data, to the next cell.
// ---------------------------------------------------------------------------
module cau_cell #(
	parameter int OW = 16,
	parameter int FB = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  cau_pkg::ctl_t ctl_i,
	input  logic [2*OW-1:0] den_i,
	input  logic [2*OW:0] rem_re_i,
	input  logic [2*OW:0] rem_im_i,
	input  logic [2*OW+FB-1:0] dvd_re_i,
	input  logic [2*OW+FB-1:0] dvd_im_i,
	input  logic [2*OW+FB-1:0] quo_re_i,
	input  logic [2*OW+FB-1:0] quo_im_i,
	input  logic [cau_pkg::RES_W-1:0] byp_re_i,
	input  logic [cau_pkg::RES_W-1:0] byp_im_i,
	output cau_pkg::ctl_t ctl_o,
	output logic [2*OW-1:0] den_o,
	output logic [2*OW:0] rem_re_o,
	output logic [2*OW:0] rem_im_o,
	output logic [2*OW+FB-1:0] dvd_re_o,
	output logic [2*OW+FB-1:0] dvd_im_o,
	output logic [2*OW+FB-1:0] quo_re_o,
	output logic [2*OW+FB-1:0] quo_im_o,
	output logic [cau_pkg::RES_W-1:0] byp_re_o,
	output logic [cau_pkg::RES_W-1:0] byp_im_o
);
	import cau_pkg::*;

	localparam int DW = 2*OW;
	localparam int QW = DW + FB;
	localparam int RW = DW + 1;

	logic [RW-1:0] t_re, t_im, d_ext, nr_re, nr_im;
	logic          ge_re, ge_im;

	always_comb begin
		d_ext = {1'b0, den_i};
		t_re  = {rem_re_i[RW-2:0], dvd_re_i[QW-1]};
		t_im  = {rem_im_i[RW-2:0], dvd_im_i[QW-1]};
		ge_re = (t_re >= d_ext);
		ge_im = (t_im >= d_ext);
		nr_re = ge_re ? t_re - d_ext : t_re;
		nr_im = ge_im ? t_im - d_ext : t_im;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (en) begin
			ctl_o <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_o    <= den_i;
			rem_re_o <= nr_re;
			rem_im_o <= nr_im;
			dvd_re_o <= {dvd_re_i[QW-2:0], 1'b0};
			dvd_im_o <= {dvd_im_i[QW-2:0], 1'b0};
			quo_re_o <= {quo_re_i[QW-2:0], ge_re};
			quo_im_o <= {quo_im_i[QW-2:0], ge_im};
			byp_re_o <= byp_re_i;
			byp_im_o <= byp_im_i;
		end
	end

endmodule

FILE: design/complex_arith_unit_top.sv
// ---------------------------------------------------------------------------
// complex_arith_unit_top: complex add, subtract, multiply and divide
// Fixed point results with FRAC_BITS fraction bits; divider as a cell chain.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one item: two signed complex operands in tdata and the
//   operation in tuser. m_axis returns one result item per input item, in
//   order: real and imaginary part in tdata, the zero-divisor flag in tuser.
//   The pipeline has one stage of multipliers, one setup stage, one divider
//   cell per quotient bit, and the output register. Add, subtract and
//   multiply results ride the same chain so order is kept.
//   Throughput is one item per cycle while the output is not stalled; the
//   chain of divider cells is fully pipelined, each cell deciding one
//   quotient bit.
//   Reset clears all valid flags; no result is presented after reset until
//   an item is accepted. When m_axis_tready is low while a result is shown,
//   the whole pipeline holds and s_axis_tready drops in the same cycle.
// ---------------------------------------------------------------------------
module complex_arith_unit_top #(
	parameter int OPERAND_WIDTH = cau_pkg::OPERAND_WIDTH_DEF,
	parameter int FRAC_BITS     = cau_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// a_real, a_imag, b_real, b_imag
	input  logic [cau_pkg::IN_DATA_W-1:0] s_axis_tdata,
	// kind
	input  logic [cau_pkg::KIND_W-1:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// res_real, res_imag, zero pad
	output logic [cau_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// div_zero
	output logic [0:0] m_axis_tuser
);
	import cau_pkg::*;

	localparam int OW  = OPERAND_WIDTH;
	localparam int FB  = FRAC_BITS;
	localparam int DW  = 2*OW;
	localparam int QW  = DW + FB;
	localparam int RW  = DW + 1;
	localparam int EXW = DW + 1;
	localparam int EW  = EXW + FB;
	localparam int CW  = (EW > RES_W + 1) ? EW : RES_W + 1;
	localparam int QCW = (QW > RES_W) ? QW : RES_W;
	localparam int NC  = QW;

	localparam logic signed [CW-1:0] POS_LIM = CW'((64'd1 << (RES_W-1)) - 64'd1);
	localparam logic signed [CW-1:0] NEG_LIM = -POS_LIM - CW'(1);
	localparam logic [QCW-1:0] Q_LIM = QCW'((64'd1 << (RES_W-1)) - 64'd1);

	function automatic logic signed [OW-1:0] take_op(input logic [IN_W-1:0] f);
		logic [31:0] e;
		e = {{(32-IN_W){f[IN_W-1]}}, f};
		return $signed(e[OW-1:0]);
	endfunction

	function automatic logic [RES_W-1:0] to_fixed(input logic signed [EXW-1:0] v);
		logic signed [CW-1:0] w;
		w = CW'(v);
		w = w <<< FB;
		if (w > POS_LIM)
			return POS_LIM[RES_W-1:0];
		else if (w < NEG_LIM)
			return NEG_LIM[RES_W-1:0];
		else
			return w[RES_W-1:0];
	endfunction

	logic en;
	logic out_valid_q;
	logic [RES_W-1:0] out_re_q, out_im_q;
	logic out_dz_q;

	assign en = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;

	// stage 1: operand select, sums or differences, and products
	logic signed [OW-1:0] ar, ai, br, bi, xr, xi, yr, yi;
	logic signed [OW:0] sr, si;
	logic swap;

	always_comb begin
		ar = take_op(s_axis_tdata[IN_W-1:0]);
		ai = take_op(s_axis_tdata[2*IN_W-1:IN_W]);
		br = take_op(s_axis_tdata[3*IN_W-1:2*IN_W]);
		bi = take_op(s_axis_tdata[4*IN_W-1:3*IN_W]);
		swap = (s_axis_tuser == K_DIV_BA);
		xr = swap ? br : ar;
		xi = swap ? bi : ai;
		yr = swap ? ar : br;
		yi = swap ? ai : bi;
		case (s_axis_tuser)
			K_SUB_AB: begin
				sr = (OW+1)'(ar) - (OW+1)'(br);
				si = (OW+1)'(ai) - (OW+1)'(bi);
			end
			K_SUB_BA: begin
				sr = (OW+1)'(br) - (OW+1)'(ar);
				si = (OW+1)'(bi) - (OW+1)'(ai);
			end
			default: begin
				sr = (OW+1)'(ar) + (OW+1)'(br);
				si = (OW+1)'(ai) + (OW+1)'(bi);
			end
		endcase
	end

	logic v_s1;
	logic [KIND_W-1:0] kind_s1;
	logic signed [DW-1:0] p0_s1, p1_s1, p2_s1, p3_s1, p4_s1, p5_s1;
	logic signed [OW:0] sr_s1, si_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= s_axis_tuser;
			p0_s1   <= xr * yr;
			p1_s1   <= xi * yi;
			p2_s1   <= xr * yi;
			p3_s1   <= xi * yr;
			p4_s1   <= yr * yr;
			p5_s1   <= yi * yi;
			sr_s1   <= sr;
			si_s1   <= si;
		end
	end

	// stage 2: exact results, numerators, denominator
	logic signed [EXW-1:0] ex_re, ex_im, num_re, num_im;
	logic [DW-1:0] den, mag_re, mag_im;
	logic is_div, known;
	ctl_t ctl_in;
	logic [RES_W-1:0] byp_re, byp_im;

	always_comb begin
		num_re = EXW'(p0_s1) + EXW'(p1_s1);
		num_im = EXW'(p3_s1) - EXW'(p2_s1);
		den    = DW'($unsigned(p4_s1)) + DW'($unsigned(p5_s1));
		is_div = (kind_s1 == K_DIV_AB) || (kind_s1 == K_DIV_BA);
		known  = 1'b1;
		case (kind_s1)
			K_ADD, K_SUB_AB, K_SUB_BA: begin
				ex_re = EXW'(sr_s1);
				ex_im = EXW'(si_s1);
			end
			K_MUL: begin
				ex_re = EXW'(p0_s1) - EXW'(p1_s1);
				ex_im = EXW'(p2_s1) + EXW'(p3_s1);
			end
			default: begin
				ex_re = '0;
				ex_im = '0;
				known = 1'b0;
			end
		endcase
		byp_re = (known && !is_div) ? to_fixed(ex_re) : '0;
		byp_im = (known && !is_div) ? to_fixed(ex_im) : '0;
		mag_re = num_re[EXW-1] ? DW'(-num_re) : DW'(num_re);
		mag_im = num_im[EXW-1] ? DW'(-num_im) : DW'(num_im);
		ctl_in.valid    = v_s1;
		ctl_in.is_div   = is_div;
		ctl_in.div_zero = is_div && (den == '0);
		ctl_in.neg_re   = num_re[EXW-1];
		ctl_in.neg_im   = num_im[EXW-1];
	end

	ctl_t ctl_c [0:NC];
	logic [DW-1:0] den_c [0:NC];
	logic [RW-1:0] rre_c [0:NC];
	logic [RW-1:0] rim_c [0:NC];
	logic [QW-1:0] dre_c [0:NC];
	logic [QW-1:0] dim_c [0:NC];
	logic [QW-1:0] qre_c [0:NC];
	logic [QW-1:0] qim_c [0:NC];
	logic [RES_W-1:0] bre_c [0:NC];
	logic [RES_W-1:0] bim_c [0:NC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_c[0] <= '0;
		end else if (en) begin
			ctl_c[0] <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_c[0] <= den;
			rre_c[0] <= '0;
			rim_c[0] <= '0;
			dre_c[0] <= QW'(mag_re) << FB;
			dim_c[0] <= QW'(mag_im) << FB;
			qre_c[0] <= '0;
			qim_c[0] <= '0;
			bre_c[0] <= byp_re;
			bim_c[0] <= byp_im;
		end
	end

	for (genvar g = 0; g < NC; g++) begin : g_cell
		cau_cell #(.OW(OW), .FB(FB)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.ctl_i    (ctl_c[g]),
			.den_i    (den_c[g]),
			.rem_re_i (rre_c[g]),
			.rem_im_i (rim_c[g]),
			.dvd_re_i (dre_c[g]),
			.dvd_im_i (dim_c[g]),
			.quo_re_i (qre_c[g]),
			.quo_im_i (qim_c[g]),
			.byp_re_i (bre_c[g]),
			.byp_im_i (bim_c[g]),
			.ctl_o    (ctl_c[g+1]),
			.den_o    (den_c[g+1]),
			.rem_re_o (rre_c[g+1]),
			.rem_im_o (rim_c[g+1]),
			.dvd_re_o (dre_c[g+1]),
			.dvd_im_o (dim_c[g+1]),
			.quo_re_o (qre_c[g+1]),
			.quo_im_o (qim_c[g+1]),
			.byp_re_o (bre_c[g+1]),
			.byp_im_o (bim_c[g+1])
		);
	end

	// output: bypass result, zero on a zero divisor, or saturated quotient magnitude with sign
	logic [QCW-1:0] qc_re, qc_im;
	logic [RES_W-1:0] qm_re, qm_im, fin_re, fin_im;
	ctl_t ctl_end;

	always_comb begin
		ctl_end = ctl_c[NC];
		qc_re = QCW'(qre_c[NC]);
		qc_im = QCW'(qim_c[NC]);
		qm_re = (qc_re > Q_LIM) ? Q_LIM[RES_W-1:0] : qc_re[RES_W-1:0];
		qm_im = (qc_im > Q_LIM) ? Q_LIM[RES_W-1:0] : qc_im[RES_W-1:0];
		if (!ctl_end.is_div) begin
			fin_re = bre_c[NC];
			fin_im = bim_c[NC];
		end else if (ctl_end.div_zero) begin
			fin_re = '0;
			fin_im = '0;
		end else begin
			fin_re = ctl_end.neg_re ? -qm_re : qm_re;
			fin_im = ctl_end.neg_im ? -qm_im : qm_im;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctl_end.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_re_q <= fin_re;
			out_im_q <= fin_im;
			out_dz_q <= ctl_end.is_div && ctl_end.div_zero;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W-2*RES_W){1'b0}}, out_im_q, out_re_q};
	assign m_axis_tuser  = out_dz_q;

`ifndef SYNTH
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("zero divisor result carries nonzero parts");
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input accepted while output stalled");
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> v_s1)
		else $error("accepted item lost at first stage");
`endif

endmodule
